[src/cpe_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpe_pkg
// Shared types, constants and saturation helpers for the complex polynomial
// evaluator.
// ----------------------------------------------------------------------------
package cpe_pkg;

    localparam int DATA_W             = 32;
    localparam int IDX_W              = 4;
    localparam int DEG_W              = 4;
    localparam int APB_AW             = 2;
    localparam int APB_DW             = 32;
    localparam int DEFAULT_MAX_DEGREE = 15;
    localparam int FRAC_BITS          = 16;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    localparam logic [APB_AW-1:0] REG_POLY_DEGREE = '0;

    localparam logic signed [63:0] SAT_MAX64 = 64'sh0000_0000_7fff_ffff;
    localparam logic signed [63:0] SAT_MIN64 = 64'shffff_ffff_8000_0000;
    localparam logic [DATA_W-1:0]  SAT_MAX32 = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0]  SAT_MIN32 = 32'h8000_0000;

    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic              ov;
    } t_sat;

    // controller to datapath
    typedef struct packed {
        logic wr;
        logic start;
        logic init;
        logic mul;
        logic cmb;
        logic acc;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic k_zero;
    } t_dp_status;

    // floor shift of a q32.32 product back to q16.16, clamped to 32 bits
    function automatic t_sat f_sat_prod(input logic signed [63:0] p);
        logic signed [63:0] q;
        t_sat               r;
        q = p >>> FRAC_BITS;
        if (q > SAT_MAX64) begin
            r.val = SAT_MAX32;
            r.ov  = 1'b1;
        end else if (q < SAT_MIN64) begin
            r.val = SAT_MIN32;
            r.ov  = 1'b1;
        end else begin
            r.val = q[DATA_W-1:0];
            r.ov  = 1'b0;
        end
        return r;
    endfunction

    function automatic t_sat f_sat_sum(input logic [DATA_W:0] s);
        t_sat r;
        if (s[DATA_W] != s[DATA_W-1]) begin
            r.val = s[DATA_W] ? SAT_MIN32 : SAT_MAX32;
            r.ov  = 1'b1;
        end else begin
            r.val = s[DATA_W-1:0];
            r.ov  = 1'b0;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[src/cpe_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpe_in_if
// Input item channel: command, coefficient write and evaluation point.
// ----------------------------------------------------------------------------
interface cpe_in_if;
    import cpe_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic [IDX_W-1:0]         coef_index;
    logic signed [DATA_W-1:0] coef_re;
    logic signed [DATA_W-1:0] coef_im;
    logic signed [DATA_W-1:0] point_re;
    logic signed [DATA_W-1:0] point_im;

    modport source (
        output valid, cmd, coef_index, coef_re, coef_im, point_re, point_im,
        input  ready
    );

    modport sink (
        input  valid, cmd, coef_index, coef_re, coef_im, point_re, point_im,
        output ready
    );
endinterface
`default_nettype wire

[src/cpe_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpe_out_if
// Result item channel: polynomial value and overflow flag.
// ----------------------------------------------------------------------------
interface cpe_out_if;
    import cpe_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value_re;
    logic signed [DATA_W-1:0] value_im;
    logic                     overflow;

    modport source (
        output valid, value_re, value_im, overflow,
        input  ready
    );

    modport sink (
        input  valid, value_re, value_im, overflow,
        output ready
    );
endinterface
`default_nettype wire

[src/complex_polynomial_evaluator_top.sv]
// Complex polynomial evaluator. A write item (cmd 0) stores one Q16.16
// complex coefficient; an evaluate item (cmd 1) runs Horner's rule over
// coefficients poly_degree down to 0 and returns one result with a sticky
// overflow flag. Each Horner step is a multiply, then a combine and
// saturate, then an add of the next coefficient. The result register is
// loaded once the last step is done, and no new item is taken until the
// evaluation has finished; the single complex multiplier feeding back into
// the accumulator sets this. A new item is taken while a result still
// waits at the output; an evaluation that finishes while that result
// still waits holds in its last cycle until the result is taken. The
// coefficient store is not cleared at reset: evaluate only after writing
// every coefficient up to the configured degree.
`default_nettype none
// ----------------------------------------------------------------------------
// complex_polynomial_evaluator_top
// Channel and register wrapper around the sequencer and the datapath.
// ----------------------------------------------------------------------------
module complex_polynomial_evaluator_top #(
    parameter int MAX_DEGREE = cpe_pkg::DEFAULT_MAX_DEGREE
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    cpe_in_if.sink                            i_in,
    cpe_out_if.source                         o_out,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [cpe_pkg::APB_AW-1:0]   paddr,
    input  wire logic [cpe_pkg::APB_DW-1:0]   pwdata,
    output logic [cpe_pkg::APB_DW-1:0]        prdata,
    output logic                              pready
);
    import cpe_pkg::*;

    logic [DEG_W-1:0] r_poly_degree;
    t_dp_cmd          w_cmd;
    t_dp_status       w_status;
    logic             w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr == REG_POLY_DEGREE) ? APB_DW'(r_poly_degree) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly_degree <= '0;
        end else if (w_cfg_wr && (paddr == REG_POLY_DEGREE)) begin
            r_poly_degree <= pwdata[DEG_W-1:0];
        end
    end

    cpe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_cmd    (i_in.cmd),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    cpe_dpath #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_poly_degree (r_poly_degree),
        .i_coef_index  (i_in.coef_index),
        .i_coef_re     (i_in.coef_re),
        .i_coef_im     (i_in.coef_im),
        .i_point_re    (i_in.point_re),
        .i_point_im    (i_in.point_im),
        .o_value_re    (o_out.value_re),
        .o_value_im    (o_out.value_im),
        .o_overflow    (o_out.overflow)
    );
endmodule
`default_nettype wire

[src/cpe_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpe_ctrl
// Sequencer for coefficient writes and Horner evaluation, plus the result
// valid flag of the output register.
// ----------------------------------------------------------------------------
module cpe_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_cmd,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output cpe_pkg::t_dp_cmd         o_cmd,
    input  wire cpe_pkg::t_dp_status i_status
);
    import cpe_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_CMB  = 3'd3;
    localparam logic [2:0] S_ACC  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_accept;
    logic       w_out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_cmd == CMD_EVAL) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_INIT;
                    end else begin
                        o_cmd.wr = 1'b1;
                    end
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = i_status.k_zero ? S_DONE : S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_CMB;
            end
            S_CMB: begin
                o_cmd.cmb = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_status.k_zero ? S_DONE : S_MUL;
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule
`default_nettype wire

[src/cpe_dpath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpe_dpath
// Coefficient memory, complex multiplier and saturating accumulator for the
// Horner recurrence, and the result register.
// ----------------------------------------------------------------------------
module cpe_dpath #(
    parameter int MAX_DEGREE = cpe_pkg::DEFAULT_MAX_DEGREE
) (
    input  wire logic                            i_clk,
    input  wire cpe_pkg::t_dp_cmd                i_cmd,
    output cpe_pkg::t_dp_status                  o_status,
    input  wire logic [cpe_pkg::DEG_W-1:0]       i_poly_degree,
    input  wire logic [cpe_pkg::IDX_W-1:0]       i_coef_index,
    input  wire logic signed [cpe_pkg::DATA_W-1:0] i_coef_re,
    input  wire logic signed [cpe_pkg::DATA_W-1:0] i_coef_im,
    input  wire logic signed [cpe_pkg::DATA_W-1:0] i_point_re,
    input  wire logic signed [cpe_pkg::DATA_W-1:0] i_point_im,
    output logic signed [cpe_pkg::DATA_W-1:0]    o_value_re,
    output logic signed [cpe_pkg::DATA_W-1:0]    o_value_im,
    output logic                                 o_overflow
);
    import cpe_pkg::*;

    localparam int DEPTH = MAX_DEGREE + 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (AW > DEG_W) ? AW : DEG_W;

    logic [2*DATA_W-1:0]      r_mem [DEPTH];
    logic [2*DATA_W-1:0]      r_rd_data;
    logic [AW-1:0]            r_k;
    logic signed [DATA_W-1:0] r_z_re;
    logic signed [DATA_W-1:0] r_z_im;
    logic signed [DATA_W-1:0] r_acc_re;
    logic signed [DATA_W-1:0] r_acc_im;
    logic signed [63:0]       r_p_rr;
    logic signed [63:0]       r_p_ii;
    logic signed [63:0]       r_p_ri;
    logic signed [63:0]       r_p_ir;
    logic signed [DATA_W-1:0] r_m_re;
    logic signed [DATA_W-1:0] r_m_im;
    logic                     r_ov;
    logic signed [DATA_W-1:0] r_out_re;
    logic signed [DATA_W-1:0] r_out_im;
    logic                     r_out_ov;

    logic [CW-1:0] w_deg_ext;
    logic [CW-1:0] w_max;
    logic [CW-1:0] w_deg_cl;
    logic [CW-1:0] w_idx_ext;
    logic          w_wr_en;
    logic          w_rd_en;
    logic [AW-1:0] w_k_dec;
    logic [AW-1:0] w_rd_addr;
    t_sat          w_s_rr;
    t_sat          w_s_ii;
    t_sat          w_s_ri;
    t_sat          w_s_ir;
    t_sat          w_s_mre;
    t_sat          w_s_mim;
    t_sat          w_s_are;
    t_sat          w_s_aim;

    // degree clamped against the store depth; writes beyond it are dropped
    assign w_deg_ext = CW'(i_poly_degree);
    assign w_max     = CW'(MAX_DEGREE);
    assign w_deg_cl  = (w_deg_ext > w_max) ? w_max : w_deg_ext;
    assign w_idx_ext = CW'(i_coef_index);
    assign w_wr_en   = i_cmd.wr && (w_idx_ext <= w_max);

    assign w_k_dec   = AW'(r_k - 1'b1);
    assign w_rd_en   = i_cmd.start || i_cmd.init || i_cmd.acc;
    assign w_rd_addr = i_cmd.start ? w_deg_cl[AW-1:0] : w_k_dec;

    assign o_status.k_zero = (r_k == '0);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_idx_ext[AW-1:0]] <= {i_coef_re, i_coef_im};
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // saturation of products, then the complex combine
    assign w_s_rr  = f_sat_prod(r_p_rr);
    assign w_s_ii  = f_sat_prod(r_p_ii);
    assign w_s_ri  = f_sat_prod(r_p_ri);
    assign w_s_ir  = f_sat_prod(r_p_ir);
    assign w_s_mre = f_sat_sum({w_s_rr.val[DATA_W-1], w_s_rr.val}
                             - {w_s_ii.val[DATA_W-1], w_s_ii.val});
    assign w_s_mim = f_sat_sum({w_s_ri.val[DATA_W-1], w_s_ri.val}
                             + {w_s_ir.val[DATA_W-1], w_s_ir.val});

    // add of the next coefficient
    assign w_s_are = f_sat_sum({r_m_re[DATA_W-1], r_m_re}
                             + {r_rd_data[2*DATA_W-1], r_rd_data[2*DATA_W-1:DATA_W]});
    assign w_s_aim = f_sat_sum({r_m_im[DATA_W-1], r_m_im}
                             + {r_rd_data[DATA_W-1], r_rd_data[DATA_W-1:0]});

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_z_re <= i_point_re;
            r_z_im <= i_point_im;
            r_k    <= w_deg_cl[AW-1:0];
        end
        if (i_cmd.init) begin
            r_acc_re <= $signed(r_rd_data[2*DATA_W-1:DATA_W]);
            r_acc_im <= $signed(r_rd_data[DATA_W-1:0]);
            r_ov     <= 1'b0;
        end
        if (i_cmd.mul) begin
            r_p_rr <= r_acc_re * r_z_re;
            r_p_ii <= r_acc_im * r_z_im;
            r_p_ri <= r_acc_re * r_z_im;
            r_p_ir <= r_acc_im * r_z_re;
            r_k    <= w_k_dec;
        end
        if (i_cmd.cmb) begin
            r_m_re <= $signed(w_s_mre.val);
            r_m_im <= $signed(w_s_mim.val);
            r_ov   <= r_ov | w_s_rr.ov | w_s_ii.ov | w_s_ri.ov | w_s_ir.ov
                    | w_s_mre.ov | w_s_mim.ov;
        end
        if (i_cmd.acc) begin
            r_acc_re <= $signed(w_s_are.val);
            r_acc_im <= $signed(w_s_aim.val);
            r_ov     <= r_ov | w_s_are.ov | w_s_aim.ov;
        end
        if (i_cmd.out_load) begin
            r_out_re <= r_acc_re;
            r_out_im <= r_acc_im;
            r_out_ov <= r_ov;
        end
    end

    assign o_value_re = r_out_re;
    assign o_value_im = r_out_im;
    assign o_overflow = r_out_ov;
endmodule
`default_nettype wire

[tb/cpe_value_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cpe_value_checker
// Watches the item channels and the register port, predicts each polynomial
// value in Q16.16 Horner order with saturation, and compares every result
// field by field against the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module cpe_value_checker #(
    parameter int MAX_DEGREE = cpe_pkg::DEFAULT_MAX_DEGREE
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    cpe_in_if                          i_in_mon,
    cpe_out_if                         i_out_mon,
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic                       i_pready,
    input  logic [cpe_pkg::APB_AW-1:0] i_paddr,
    input  logic [cpe_pkg::APB_DW-1:0] i_pwdata,
    output int                         o_fail_count,
    output int                         o_pending
);
    import cpe_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
        logic                     ovf;
    } t_poly_value;

    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;

    logic signed [DATA_W-1:0] coef_re_mem [MAX_DEGREE+1];
    logic signed [DATA_W-1:0] coef_im_mem [MAX_DEGREE+1];
    logic [DEG_W-1:0]         degree_reg = '0;
    t_poly_value              poly_values [$];
    int                       fail_count = 0;

    function automatic longint clamp_q(input longint v, inout bit ovf);
        if (v > Q_MAX) begin
            ovf = 1'b1;
            return Q_MAX;
        end
        if (v < Q_MIN) begin
            ovf = 1'b1;
            return Q_MIN;
        end
        return v;
    endfunction

    // exact product, floor shift back to q16.16, then clamp
    function automatic longint mul_q16(input longint a, input longint b, inout bit ovf);
        longint prod;
        prod = a * b;
        return clamp_q(prod >>> FRAC_BITS, ovf);
    endfunction

    function automatic t_poly_value horner_value(input longint zr, input longint zi);
        t_poly_value res;
        longint      ar, ai, rr, ii, ri, ir, mr, mi;
        int          d;
        bit          ovf;
        d   = (int'(degree_reg) > MAX_DEGREE) ? MAX_DEGREE : int'(degree_reg);
        ovf = 1'b0;
        ar  = longint'(coef_re_mem[d]);
        ai  = longint'(coef_im_mem[d]);
        for (int k = d - 1; k >= 0; k--) begin
            rr = mul_q16(ar, zr, ovf);
            ii = mul_q16(ai, zi, ovf);
            ri = mul_q16(ar, zi, ovf);
            ir = mul_q16(ai, zr, ovf);
            mr = clamp_q(rr - ii, ovf);
            mi = clamp_q(ri + ir, ovf);
            ar = clamp_q(mr + longint'(coef_re_mem[k]), ovf);
            ai = clamp_q(mi + longint'(coef_im_mem[k]), ovf);
        end
        res.re  = ar[DATA_W-1:0];
        res.im  = ai[DATA_W-1:0];
        res.ovf = ovf;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_poly_value exp_v;
        if (!i_rst_n) begin
            degree_reg = '0;
            poly_values.delete();
        end else begin
            if (i_out_mon.valid === 1'b1 && i_out_mon.ready === 1'b1) begin
                if (poly_values.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result item: re %h im %h overflow %b",
                             $time, i_out_mon.value_re, i_out_mon.value_im,
                             i_out_mon.overflow);
                end else begin
                    exp_v = poly_values.pop_front();
                    if (i_out_mon.value_re !== exp_v.re) begin
                        fail_count++;
                        $display("%0t: value_re expected %h actual %h",
                                 $time, exp_v.re, i_out_mon.value_re);
                    end
                    if (i_out_mon.value_im !== exp_v.im) begin
                        fail_count++;
                        $display("%0t: value_im expected %h actual %h",
                                 $time, exp_v.im, i_out_mon.value_im);
                    end
                    if (i_out_mon.overflow !== exp_v.ovf) begin
                        fail_count++;
                        $display("%0t: overflow expected %b actual %b",
                                 $time, exp_v.ovf, i_out_mon.overflow);
                    end
                end
            end
            if (i_in_mon.valid === 1'b1 && i_in_mon.ready === 1'b1) begin
                if (i_in_mon.cmd == CMD_WRITE) begin
                    if (int'(i_in_mon.coef_index) <= MAX_DEGREE) begin
                        coef_re_mem[i_in_mon.coef_index] = i_in_mon.coef_re;
                        coef_im_mem[i_in_mon.coef_index] = i_in_mon.coef_im;
                    end
                end else begin
                    poly_values.insert(poly_values.size(),
                                       horner_value(longint'(i_in_mon.point_re),
                                                    longint'(i_in_mon.point_im)));
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready
                && i_paddr == REG_POLY_DEGREE) begin
                degree_reg = i_pwdata[DEG_W-1:0];
            end
        end
        o_pending    <= poly_values.size();
        o_fail_count <= fail_count;
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the complex polynomial evaluator: coefficient writes and
// evaluations over several degree settings, with random idling on both
// channels, one long result stall and a drain before every register write.
// ----------------------------------------------------------------------------
module tb;
    import cpe_pkg::*;

    localparam int          MAX_IDLE      = 12;
    localparam int          SETTLE_CYCLES = 3 * DEFAULT_MAX_DEGREE + 19;
    localparam int          LONG_HOLD     = 400;
    localparam int          PHASES        = 10;
    localparam int          PHASE_ITEMS   = 108;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          DEG_TOP       = (1 << DEG_W) - 1;
    localparam int unsigned ONE           = 1 << FRAC_BITS;
    localparam int unsigned COEF_SPAN     = 1 << 20;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    int                fail_count;
    int                pending;
    int                cycle_cnt;
    bit                quiet_tx      = 1'b0;
    bit                quiet_rx      = 1'b0;
    bit                long_hold_req = 1'b0;

    cpe_in_if  in_ch ();
    cpe_out_if out_ch ();

    complex_polynomial_evaluator_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    cpe_value_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("[complex_polynomial_evaluator_top] ERROR");
        $finish;
    end

    function automatic logic [DATA_W-1:0] q16_rand(input int unsigned span);
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            return SAT_MAX32;
        end
        if (pick == 1) begin
            return SAT_MIN32;
        end
        if (pick < 5) begin
            return $urandom;
        end
        return $urandom_range(0, 2 * span) - span;
    endfunction

    task automatic send_item(input logic cmd, input logic [IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] c_re, input logic [DATA_W-1:0] c_im,
                             input logic [DATA_W-1:0] z_re, input logic [DATA_W-1:0] z_im);
        int unsigned gap;
        gap = quiet_tx ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.cmd        <= cmd;
        in_ch.coef_index <= idx;
        in_ch.coef_re    <= c_re;
        in_ch.coef_im    <= c_im;
        in_ch.point_re   <= z_re;
        in_ch.point_im   <= z_im;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
    endtask

    task automatic write_coef(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] c_re,
                              input logic [DATA_W-1:0] c_im);
        send_item(CMD_WRITE, idx, c_re, c_im, $urandom, $urandom);
    endtask

    task automatic eval_at(input logic [DATA_W-1:0] z_re, input logic [DATA_W-1:0] z_im);
        send_item(CMD_EVAL, IDX_W'($urandom), $urandom, $urandom, z_re, z_im);
    endtask

    // wait until every predicted value has come back and the block is quiet
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_degree(input int unsigned deg);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_POLY_DEGREE;
        pwdata  <= APB_DW'(deg);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin : result_sink
        int unsigned wait_cycles;
        forever begin
            if (long_hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_req = 1'b0;
            end
            wait_cycles = quiet_rx ? 0 : $urandom_range(0, MAX_IDLE);
            if (wait_cycles != 0) begin
                out_ch.ready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk);
            while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
            if ($urandom_range(0, 24) == 0) begin
                quiet_rx = !quiet_rx;
            end
        end
    end

    initial begin : stimulus
        int          k;
        int          phase;
        int          n;
        int unsigned deg;
        i_rst_n          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.cmd        <= CMD_WRITE;
        in_ch.coef_index <= '0;
        in_ch.coef_re    <= '0;
        in_ch.coef_im    <= '0;
        in_ch.point_re   <= '0;
        in_ch.point_im   <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the whole store, extremes at both ends
        write_coef(IDX_W'(0), SAT_MAX32, SAT_MIN32);
        for (k = 1; k < DEG_TOP; k++) begin
            write_coef(IDX_W'(k), q16_rand(ONE), q16_rand(ONE));
        end
        write_coef(IDX_W'(DEG_TOP), SAT_MIN32, SAT_MAX32);

        // degree zero returns coefficient 0 untouched
        eval_at(SAT_MIN32, SAT_MAX32);
        drain_results();

        set_degree(DEG_TOP);
        eval_at('0, '0);
        eval_at(ONE, '0);
        eval_at('0, ONE);
        eval_at(SAT_MAX32, SAT_MAX32);
        eval_at(SAT_MIN32, SAT_MIN32);
        eval_at('1, '1);

        for (phase = 0; phase < PHASES; phase++) begin
            drain_results();
            if (phase == 0) begin
                deg = 0;
            end else if (phase == 1 || phase == PHASES - 1) begin
                deg = DEG_TOP;
            end else begin
                deg = $urandom_range(0, DEG_TOP);
            end
            set_degree(deg);
            if (phase == 3) begin
                long_hold_req = 1'b1;
            end
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 39) == 0) begin
                    quiet_tx = !quiet_tx;
                end
                if ($urandom_range(0, 99) < 45) begin
                    eval_at(q16_rand(ONE), q16_rand(ONE));
                end else begin
                    write_coef(IDX_W'($urandom), q16_rand(COEF_SPAN), q16_rand(COEF_SPAN));
                end
            end
        end

        drain_results();
        if (fail_count == 0) begin
            $display("[complex_polynomial_evaluator_top] OK");
        end else begin
            $display("[complex_polynomial_evaluator_top] ERROR");
        end
        $finish;
    end

endmodule

[files.f]
src/cpe_pkg.sv
src/cpe_in_if.sv
src/cpe_out_if.sv
src/cpe_ctrl.sv
src/cpe_dpath.sv
src/complex_polynomial_evaluator_top.sv
tb/cpe_value_checker.sv
tb/tb.sv
